>>> rtl/swm_pkg.sv
// Shared constants and types for the sliding window median filter.
`default_nettype none

package swm_pkg;

   localparam int SAMPLE_W       = 16;
   localparam int CFG_W          = 5;
   localparam int MAX_WINDOW_DEF = 16;
   localparam int WINDOW_RESET   = 16;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;

   // register index, taken from paddr above the byte offset
   localparam logic REG_WINDOW_SIZE = 1'b0;

   typedef struct packed {
      logic clear;
      logic load;
      logic evict;
   } cell_ctrl_type;

endpackage

`default_nettype wire

>>> rtl/swm_cell.sv
// One cell of the sorted chain: holds a sample, its store tag and a valid bit.
`default_nettype none

module swm_cell #(
   parameter int TAG_W = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire swm_pkg::cell_ctrl_type     ctrl,
   input  wire logic [swm_pkg::SAMPLE_W-1:0] sample,
   input  wire logic [TAG_W-1:0]           wr_tag,
   input  wire logic                       left_del,
   input  wire logic [swm_pkg::SAMPLE_W-1:0] left_val,
   input  wire logic [TAG_W-1:0]           left_tag,
   input  wire logic                       left_vld,
   input  wire logic [swm_pkg::SAMPLE_W-1:0] right_val,
   input  wire logic [TAG_W-1:0]           right_tag,
   input  wire logic                       right_vld,
   output logic                            del_out,
   output logic [swm_pkg::SAMPLE_W-1:0]    own_val,
   output logic [TAG_W-1:0]                own_tag,
   output logic                            own_vld,
   output logic [swm_pkg::SAMPLE_W-1:0]    post_val,
   output logic [TAG_W-1:0]                post_tag,
   output logic                            post_vld
);
   import swm_pkg::*;

   logic [SAMPLE_W-1:0] val_ff, val_in;
   logic [TAG_W-1:0]    tag_ff, tag_in;
   logic                vld_ff, vld_in;
   logic                match;
   logic                left_gt;
   logic                post_gt;

   assign own_val = val_ff;
   assign own_tag = tag_ff;
   assign own_vld = vld_ff;

   // the entry being evicted is this one, or lies to the left
   assign match   = ctrl.evict && vld_ff && (tag_ff == wr_tag);
   assign del_out = left_del || match;

   // close the gap left by the evicted entry
   always_comb begin
      if (del_out) begin
         post_val = right_val;
         post_tag = right_tag;
         post_vld = right_vld;
      end else begin
         post_val = val_ff;
         post_tag = tag_ff;
         post_vld = vld_ff;
      end
   end

   // an empty cell counts as larger than any sample
   assign left_gt = !left_vld || (left_val > sample);
   assign post_gt = !post_vld || (post_val > sample);

   always_comb begin
      if (left_gt) begin
         val_in = left_val;
         tag_in = left_tag;
         vld_in = left_vld;
      end else if (post_gt) begin
         val_in = sample;
         tag_in = wr_tag;
         vld_in = 1'b1;
      end else begin
         val_in = post_val;
         tag_in = post_tag;
         vld_in = post_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         vld_ff <= 1'b0;
      end else if (ctrl.load) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         val_ff <= val_in;
         tag_ff <= tag_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/swm_chain.sv
// Row of sorted cells with the middle-pair select and average.
`default_nettype none

module swm_chain #(
   parameter int DEPTH = swm_pkg::MAX_WINDOW_DEF,
   parameter int TAG_W = 4
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire swm_pkg::cell_ctrl_type       ctrl,
   input  wire logic [swm_pkg::SAMPLE_W-1:0] sample,
   input  wire logic [TAG_W-1:0]             wr_tag,
   input  wire logic [TAG_W-1:0]             lo_idx,
   input  wire logic [TAG_W-1:0]             hi_idx,
   output logic [swm_pkg::SAMPLE_W-1:0]      median
);
   import swm_pkg::*;

   logic [SAMPLE_W-1:0] own_val  [DEPTH];
   logic [TAG_W-1:0]    own_tag  [DEPTH];
   logic                own_vld  [DEPTH];
   logic [SAMPLE_W-1:0] post_val [DEPTH];
   logic [TAG_W-1:0]    post_tag [DEPTH];
   logic                post_vld [DEPTH];
   logic                del      [DEPTH];

   logic [SAMPLE_W-1:0] lo_val;
   logic [SAMPLE_W-1:0] hi_val;
   logic [SAMPLE_W:0]   pair_sum;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                lft_del;
      logic [SAMPLE_W-1:0] lft_val;
      logic [TAG_W-1:0]    lft_tag;
      logic                lft_vld;
      logic [SAMPLE_W-1:0] rgt_val;
      logic [TAG_W-1:0]    rgt_tag;
      logic                rgt_vld;

      // the head sees a floor of zero that no sample lies below
      if (i == 0) begin : g_head
         assign lft_del = 1'b0;
         assign lft_val = '0;
         assign lft_tag = '0;
         assign lft_vld = 1'b1;
      end else begin : g_body
         assign lft_del = del[i-1];
         assign lft_val = post_val[i-1];
         assign lft_tag = post_tag[i-1];
         assign lft_vld = post_vld[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign rgt_val = '0;
         assign rgt_tag = '0;
         assign rgt_vld = 1'b0;
      end else begin : g_next
         assign rgt_val = own_val[i+1];
         assign rgt_tag = own_tag[i+1];
         assign rgt_vld = own_vld[i+1];
      end

      swm_cell #(
         .TAG_W(TAG_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .sample    (sample),
         .wr_tag    (wr_tag),
         .left_del  (lft_del),
         .left_val  (lft_val),
         .left_tag  (lft_tag),
         .left_vld  (lft_vld),
         .right_val (rgt_val),
         .right_tag (rgt_tag),
         .right_vld (rgt_vld),
         .del_out   (del[i]),
         .own_val   (own_val[i]),
         .own_tag   (own_tag[i]),
         .own_vld   (own_vld[i]),
         .post_val  (post_val[i]),
         .post_tag  (post_tag[i]),
         .post_vld  (post_vld[i])
      );
   end

   // pick the two middle cells; for an odd count both indexes are equal
   always_comb begin
      lo_val = '0;
      hi_val = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (lo_idx == TAG_W'(i)) begin
            lo_val = lo_val | own_val[i];
         end
         if (hi_idx == TAG_W'(i)) begin
            hi_val = hi_val | own_val[i];
         end
      end
   end

   assign pair_sum = {1'b0, lo_val} + {1'b0, hi_val};
   assign median   = pair_sum[SAMPLE_W:1];

endmodule

`default_nettype wire

>>> rtl/sliding_window_median.sv
// Sliding window median filter: top level with control, register port and result register.
//
// For each accepted sample: at the accept edge the sorted cell chain drops the
// oldest sample (once the window is full) and inserts the new one in order, and in
// the next cycle the two middle cells are averaged into the result register.
// req_ready is low while that average is registered and rises in the cycle after
// it once the result register is free or being read, so a new sample is not taken
// before the previous one has reached the result register.
// The window size register (address 0) clamps to 1..MAX_WINDOW and writing it
// clears the history; write it only while no transaction is in flight.
`default_nettype none

module sliding_window_median #(
   parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [swm_pkg::SAMPLE_W-1:0]   req_sample,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [swm_pkg::SAMPLE_W-1:0]        rsp_median,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [swm_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [swm_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [swm_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);
   import swm_pkg::*;

   localparam int IDX_RAW = $clog2(MAX_WINDOW);
   localparam int IDX_W   = (IDX_RAW < 1) ? 1 : IDX_RAW;
   localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
   localparam int SZ_W    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam int RST_SZ  = (WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW : WINDOW_RESET;

   logic [CNT_W-1:0]    size_ff, size_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic [IDX_W-1:0]    wpos_ff, wpos_in;
   logic                pend_ff;
   logic                rsp_valid_ff;
   logic [SAMPLE_W-1:0] rsp_median_ff;

   logic                cfg_wr;
   logic                accept;
   logic                full;
   logic [SZ_W-1:0]     wdata_ext;
   logic [CNT_W-1:0]    fill_dec;
   logic [IDX_W-1:0]    lo_idx;
   logic [IDX_W-1:0]    hi_idx;
   logic [SAMPLE_W-1:0] median;
   cell_ctrl_type       ctrl;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && (paddr[CSR_ADDR_W-1] == REG_WINDOW_SIZE);

   always_comb begin
      if (paddr[CSR_ADDR_W-1] == REG_WINDOW_SIZE) begin
         prdata = CSR_DATA_W'(size_ff);
      end else begin
         prdata = '0;
      end
   end

   // clamp the written size to 1..MAX_WINDOW
   assign wdata_ext = SZ_W'(pwdata[CFG_W-1:0]);
   always_comb begin
      if (wdata_ext > SZ_W'(MAX_WINDOW)) begin
         size_in = CNT_W'(MAX_WINDOW);
      end else if (wdata_ext == '0) begin
         size_in = CNT_W'(1);
      end else begin
         size_in = wdata_ext[CNT_W-1:0];
      end
   end

   assign req_ready = !pend_ff && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign full      = (fill_ff == size_ff);

   always_comb begin
      if (full) begin
         fill_in = fill_ff;
      end else begin
         fill_in = fill_ff + CNT_W'(1);
      end
      if ((CNT_W'(wpos_ff) + CNT_W'(1)) == size_ff) begin
         wpos_in = '0;
      end else begin
         wpos_in = wpos_ff + IDX_W'(1);
      end
   end

   assign ctrl.clear = cfg_wr;
   assign ctrl.load  = accept;
   assign ctrl.evict = full;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= CNT_W'(RST_SZ);
         fill_ff <= '0;
         wpos_ff <= '0;
      end else if (cfg_wr) begin
         size_ff <= size_in;
         fill_ff <= '0;
         wpos_ff <= '0;
      end else if (accept) begin
         fill_ff <= fill_in;
         wpos_ff <= wpos_in;
      end
   end

   // middle pair of the sorted row, taken from the updated count
   assign fill_dec = fill_ff - CNT_W'(1);
   assign lo_idx   = IDX_W'(fill_dec >> 1);
   assign hi_idx   = IDX_W'(fill_ff >> 1);

   swm_chain #(
      .DEPTH (MAX_WINDOW),
      .TAG_W (IDX_W)
   ) u_chain (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .sample (req_sample),
      .wr_tag (wpos_ff),
      .lo_idx (lo_idx),
      .hi_idx (hi_idx),
      .median (median)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff <= accept;
         if (pend_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pend_ff) begin
         rsp_median_ff <= median;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_median = rsp_median_ff;

endmodule

`default_nettype wire
